// ===== rtl/odc_pkg.sv =====
// Package for the ordered-dither RGB to 216-color cube quantizer.
// Holds the 16x16 threshold ROM, level constants and register indexes.
// No dependencies.
package odc_pkg;

    localparam int CHAN_W   = 8;
    localparam int PHASE_W  = 4;
    localparam int LEVEL_W  = 3;
    localparam int INDEX_W  = 8;
    localparam int CFG_IDX_W = 1;

    // Ordered gain 256*5 + 5 + 1, threshold scale 5, rounding offset 127
    localparam logic [10:0] ORDERED_GAIN = 11'd1286;
    localparam logic [2:0]  TOP_LEVEL    = 3'd5;
    localparam logic [6:0]  ROUND_BIAS   = 7'd127;
    localparam logic [7:0]  CHAN_MAX     = 8'd255;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_DITHER_MODE       = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TRANSPARENT_INDEX = 1'd1;

    // Dither mode codes
    localparam logic MODE_ORDERED   = 1'b0;
    localparam logic MODE_THRESHOLD = 1'b1;

    localparam logic [INDEX_W-1:0] TRANSPARENT_RESET = 8'd255;

    // Threshold ROM, entry row*16 + column
    localparam logic [7:0] BAYER_ROM [256] = '{
        8'h01,8'hc0,8'h30,8'hf0,8'h0c,8'hcc,8'h3c,8'hfc,
        8'h03,8'hc3,8'h33,8'hf3,8'h0f,8'hcf,8'h3f,8'hff,
        8'h80,8'h40,8'hb0,8'h70,8'h8c,8'h4c,8'hbc,8'h7c,
        8'h83,8'h43,8'hb3,8'h73,8'h8f,8'h4f,8'hbf,8'h7f,
        8'h20,8'he0,8'h10,8'hd0,8'h2c,8'hec,8'h1c,8'hdc,
        8'h23,8'he3,8'h13,8'hd3,8'h2f,8'hef,8'h1f,8'hdf,
        8'ha0,8'h60,8'h90,8'h50,8'hac,8'h6c,8'h9c,8'h5c,
        8'ha3,8'h63,8'h93,8'h53,8'haf,8'h6f,8'h9f,8'h5f,
        8'h08,8'hc8,8'h38,8'hf8,8'h04,8'hc4,8'h34,8'hf4,
        8'h0b,8'hcb,8'h3b,8'hfb,8'h07,8'hc7,8'h37,8'hf7,
        8'h88,8'h48,8'hb8,8'h78,8'h84,8'h44,8'hb4,8'h74,
        8'h8b,8'h4b,8'hbb,8'h7b,8'h87,8'h47,8'hb7,8'h77,
        8'h28,8'he8,8'h18,8'hd8,8'h24,8'he4,8'h14,8'hd4,
        8'h2b,8'heb,8'h1b,8'hdb,8'h27,8'he7,8'h17,8'hd7,
        8'ha8,8'h68,8'h98,8'h58,8'ha4,8'h64,8'h94,8'h54,
        8'hab,8'h6b,8'h9b,8'h5b,8'ha7,8'h67,8'h97,8'h57,
        8'h02,8'hc2,8'h32,8'hf2,8'h0e,8'hce,8'h3e,8'hfe,
        8'h01,8'hc1,8'h31,8'hf1,8'h0d,8'hcd,8'h3d,8'hfd,
        8'h82,8'h42,8'hb2,8'h72,8'h8e,8'h4e,8'hbe,8'h7e,
        8'h81,8'h41,8'hb1,8'h71,8'h8d,8'h4d,8'hbd,8'h7d,
        8'h22,8'he2,8'h12,8'hd2,8'h2e,8'hee,8'h1e,8'hde,
        8'h21,8'he1,8'h11,8'hd1,8'h2d,8'hed,8'h1d,8'hdd,
        8'ha2,8'h62,8'h92,8'h52,8'hae,8'h6e,8'h9e,8'h5e,
        8'ha1,8'h61,8'h91,8'h51,8'had,8'h6d,8'h9d,8'h5d,
        8'h0a,8'hca,8'h3a,8'hfa,8'h06,8'hc6,8'h36,8'hf6,
        8'h09,8'hc9,8'h39,8'hf9,8'h05,8'hc5,8'h35,8'hf5,
        8'h8a,8'h4a,8'hba,8'h7a,8'h86,8'h46,8'hb6,8'h76,
        8'h89,8'h49,8'hb9,8'h79,8'h85,8'h45,8'hb5,8'h75,
        8'h2a,8'hea,8'h1a,8'hda,8'h26,8'he6,8'h16,8'hd6,
        8'h29,8'he9,8'h19,8'hd9,8'h25,8'he5,8'h15,8'hd5,
        8'haa,8'h6a,8'h9a,8'h5a,8'ha6,8'h66,8'h96,8'h56,
        8'ha9,8'h69,8'h99,8'h59,8'ha5,8'h65,8'h95,8'h55
    };

endpackage

// ===== rtl/odc_if.sv =====
// Channel interfaces for the cube quantizer: pixel in, index out, config write.
// Depends on odc_pkg.
interface odc_pixel_if import odc_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [CHAN_W-1:0]  red;
    logic [CHAN_W-1:0]  green;
    logic [CHAN_W-1:0]  blue;
    logic               opaque;
    logic [PHASE_W-1:0] column_phase;
    logic [PHASE_W-1:0] row_phase;

    modport source (output valid, red, green, blue, opaque, column_phase, row_phase,
                    input ready);
    modport sink   (input valid, red, green, blue, opaque, column_phase, row_phase,
                    output ready);
endinterface

interface odc_index_if import odc_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [INDEX_W-1:0] palette_index;

    modport source (output valid, palette_index, input ready);
    modport sink   (input valid, palette_index, output ready);
endinterface

interface odc_cfg_if import odc_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [INDEX_W-1:0]   data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/ordered_dither_rgb_to_cube216.sv =====
// Top level of the ordered-dither RGB to 6x6x6 color cube quantizer.
// Depends on odc_pkg, odc_if and odc_level.
// Three-stage pipeline taking one pixel per clock when the output is not
// back-pressured. Stage 1 reads the 16x16 threshold ROM, stage 2 computes the
// three channel levels (one odc_level each), stage 3 forms (r*6+g)*6+b or the
// transparent index. Each stage holds its beat under back-pressure and reloads
// as soon as the stage after it moves, so stalls lose nothing. Registers are
// written through the config channel, which is always ready; write them only
// while the pipeline is empty.
module ordered_dither_rgb_to_cube216 import odc_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    odc_cfg_if.sink     i_cfg,
    odc_pixel_if.sink   i_pix,
    odc_index_if.source o_idx
);

    // Configuration registers
    logic               r_mode;
    logic [INDEX_W-1:0] r_transparent;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode        <= MODE_ORDERED;
            r_transparent <= TRANSPARENT_RESET;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                REG_DITHER_MODE:       r_mode        <= i_cfg.data[0];
                REG_TRANSPARENT_INDEX: r_transparent <= i_cfg.data;
                default: ;
            endcase
        end
    end

    // Stage load enables
    logic w_ld1, w_ld2, w_ld3;
    logic r_v1, r_v2, r_v3;

    assign w_ld3       = !r_v3 || o_idx.ready;
    assign w_ld2       = !r_v2 || w_ld3;
    assign w_ld1       = !r_v1 || w_ld2;
    assign i_pix.ready = w_ld1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (w_ld1) r_v1 <= i_pix.valid;
            if (w_ld2) r_v2 <= r_v1;
            if (w_ld3) r_v3 <= r_v2;
        end
    end

    // Stage 1: threshold ROM read
    logic [CHAN_W-1:0] r_s1_red, r_s1_green, r_s1_blue;
    logic [7:0]        r_s1_bias;
    logic              r_s1_opaque;

    always_ff @(posedge i_clk) begin
        if (w_ld1) begin
            r_s1_red    <= i_pix.red;
            r_s1_green  <= i_pix.green;
            r_s1_blue   <= i_pix.blue;
            r_s1_opaque <= i_pix.opaque;
            r_s1_bias   <= BAYER_ROM[{i_pix.row_phase, i_pix.column_phase}];
        end
    end

    // Stage 2: channel levels
    logic [LEVEL_W-1:0] w_lr, w_lg, w_lb;
    logic [LEVEL_W-1:0] r_s2_lr, r_s2_lg, r_s2_lb;
    logic               r_s2_opaque;

    odc_level u_level_r (.i_mode(r_mode), .i_chan(r_s1_red),   .i_bias(r_s1_bias),
                         .o_level(w_lr));
    odc_level u_level_g (.i_mode(r_mode), .i_chan(r_s1_green), .i_bias(r_s1_bias),
                         .o_level(w_lg));
    odc_level u_level_b (.i_mode(r_mode), .i_chan(r_s1_blue),  .i_bias(r_s1_bias),
                         .o_level(w_lb));

    always_ff @(posedge i_clk) begin
        if (w_ld2) begin
            r_s2_lr     <= w_lr;
            r_s2_lg     <= w_lg;
            r_s2_lb     <= w_lb;
            r_s2_opaque <= r_s1_opaque;
        end
    end

    // Stage 3: cube index or transparent index
    logic [INDEX_W-1:0] w_cube;
    logic [INDEX_W-1:0] r_s3_index;

    assign w_cube = 8'(r_s2_lr) * 8'd36 + 8'(r_s2_lg) * 8'd6 + 8'(r_s2_lb);

    always_ff @(posedge i_clk) begin
        if (w_ld3) begin
            r_s3_index <= r_s2_opaque ? w_cube : r_transparent;
        end
    end

    assign o_idx.valid         = r_v3;
    assign o_idx.palette_index = r_s3_index;

endmodule

// ===== rtl/odc_level.sv =====
// One channel's 0..5 level: ordered dither or rounding threshold.
// Depends on odc_pkg.
module odc_level import odc_pkg::*; (
    input  logic               i_mode,
    input  logic [CHAN_W-1:0]  i_chan,
    input  logic [7:0]         i_bias,
    output logic [LEVEL_W-1:0] o_level
);

    logic [18:0] w_ordered;
    logic [10:0] w_scaled;
    logic [LEVEL_W-1:0] w_thresh;

    // Ordered: (1286*chan + bias<<8) >> 16
    assign w_ordered = 19'(ORDERED_GAIN) * 19'(i_chan) + {3'd0, i_bias, 8'd0};

    // Threshold: (chan*5 + 127) / 255 by counting multiples of 255 crossed
    assign w_scaled = 11'(i_chan) * 11'(TOP_LEVEL) + 11'(ROUND_BIAS);

    always_comb begin
        w_thresh = '0;
        for (int k = 1; k <= 5; k++) begin
            if (w_scaled >= 11'(k) * 11'(CHAN_MAX)) begin
                w_thresh = w_thresh + 3'd1;
            end
        end
    end

    assign o_level = (i_mode == MODE_THRESHOLD) ? w_thresh : w_ordered[18:16];

endmodule
